>>> src/utf8d_pkg.sv
// Shared types, codes and helper functions for the UTF-8 decoder.
`default_nettype none

package utf8d_pkg;

    // Depth of the queue between the classifying front and the decoding back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNC     = 3'd1,
        ST_BADCONT   = 3'd2,
        ST_OVERLONG  = 3'd3,
        ST_SURROGATE = 3'd4,
        ST_RANGE4    = 3'd5,
        ST_BADLEAD   = 3'd6
    } t_status;

    // Byte classes found by the front.
    typedef enum logic [2:0] {
        BC_ASCII = 3'd0,
        BC_LEAD2 = 3'd1,
        BC_LEAD3 = 3'd2,
        BC_LEAD4 = 3'd3,
        BC_CONT  = 3'd4,
        BC_BAD   = 3'd5
    } t_byte_class;

    // Input word: one byte of the string.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_word;

    // Output word: one decoded result.
    typedef struct packed {
        logic [20:0] code_point;
        t_status     status;
        logic        string_done;
    } t_out_word;

    // Classified byte as it travels through the queue.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_string;
        t_byte_class cls;
    } t_cls_word;

    // Sort a raw byte by its leading bit pattern.
    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        if (!b[7]) begin
            c = BC_ASCII;
        end else if (b[7:5] == 3'b110) begin
            c = BC_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            c = BC_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            c = BC_LEAD4;
        end else if (b[7:6] == 2'b10) begin
            c = BC_CONT;
        end else begin
            c = BC_BAD;
        end
        return c;
    endfunction

    // Range checks on a completed sequence; len_m1 is its length minus one.
    function automatic t_status check_done(input logic [1:0] len_m1, input logic [20:0] v);
        t_status s;
        s = ST_OK;
        case (len_m1)
            2'd1: begin
                if (v < 21'h000080) s = ST_OVERLONG;
            end
            2'd2: begin
                if (v < 21'h000800) begin
                    s = ST_OVERLONG;
                end else if (v >= 21'h00D800 && v <= 21'h00DFFF) begin
                    s = ST_SURROGATE;
                end
            end
            default: begin
                if (v < 21'h010000 || v > 21'h10FFFF) s = ST_RANGE4;
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/utf8d_front.sv
// Front stage: takes input words, classifies each byte and holds it for the queue.
`default_nettype none

module utf8d_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  utf8d_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  wire                  i_ready,
    output utf8d_pkg::t_cls_word o_word
);
    import utf8d_pkg::*;

    logic      r_valid;
    t_cls_word r_word;
    logic      load;

    // The stage refills whenever it is empty or its word moves on.
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload with its byte class.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word.data_byte     <= i_word.data_byte;
            r_word.end_of_string <= i_word.end_of_string;
            r_word.cls           <= classify(i_word.data_byte);
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> src/utf8d_queue.sv
// Short queue of classified bytes between the front and the back.
`default_nettype none

module utf8d_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  utf8d_pkg::t_cls_word i_word,
    output logic                 o_valid,
    input  wire                  i_ready,
    output utf8d_pkg::t_cls_word o_word
);
    import utf8d_pkg::*;

    t_cls_word          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance a pointer with wrap at the queue depth.
    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] n;
        if (p == QPTR_W'(QDEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + QPTR_W'(1);
        end
        return n;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= next_ptr(r_wr_ptr);
            if (pop)  r_rd_ptr <= next_ptr(r_rd_ptr);
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_word;
    end

    assign o_word = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> src/utf8d_back.sv
// Back stage: runs the sequence decoder on classified bytes and registers the results.
`default_nettype none

module utf8d_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  utf8d_pkg::t_cls_word i_word,
    output logic                 o_valid,
    input  wire                  i_ready,
    output utf8d_pkg::t_out_word o_word
);
    import utf8d_pkg::*;

    logic [1:0]  r_pending;
    logic [1:0]  r_seq_len;
    logic [20:0] r_partial;
    logic        r_dropping;
    logic        r_out_valid;
    t_out_word   r_out;

    logic [1:0]  n_pending;
    logic [1:0]  n_seq_len;
    logic [20:0] n_partial;
    logic        n_dropping;
    t_out_word   n_out;

    logic        pop;
    logic        emit;
    logic        eos;
    logic        is_lead;
    t_status     st;
    logic [20:0] new_part;

    // A byte is taken when the output register is free or being emptied.
    assign o_ready  = !r_out_valid || i_ready;
    assign pop      = i_valid && o_ready;
    assign eos      = i_word.end_of_string;
    assign new_part = {r_partial[14:0], i_word.data_byte[5:0]};

    // Sequence decoding for one popped byte.
    always_comb begin
        n_pending  = r_pending;
        n_seq_len  = r_seq_len;
        n_partial  = r_partial;
        n_dropping = r_dropping;
        emit       = 1'b0;
        is_lead    = 1'b0;
        st         = ST_OK;
        n_out.code_point  = '0;
        n_out.string_done = eos;
        if (pop) begin
            if (r_dropping) begin
                // Bytes after a fault are dropped until the end mark.
                if (eos) n_dropping = 1'b0;
            end else if (r_pending == 2'd0) begin
                case (i_word.cls)
                    BC_ASCII: begin
                        emit = 1'b1;
                        n_out.code_point = {13'd0, i_word.data_byte};
                    end
                    BC_LEAD2: begin
                        is_lead   = 1'b1;
                        n_seq_len = 2'd1;
                        n_partial = {16'd0, i_word.data_byte[4:0]};
                    end
                    BC_LEAD3: begin
                        is_lead   = 1'b1;
                        n_seq_len = 2'd2;
                        n_partial = {17'd0, i_word.data_byte[3:0]};
                    end
                    BC_LEAD4: begin
                        is_lead   = 1'b1;
                        n_seq_len = 2'd3;
                        n_partial = {18'd0, i_word.data_byte[2:0]};
                    end
                    default: begin
                        emit = 1'b1;
                        st   = ST_BADLEAD;
                    end
                endcase
                if (is_lead) begin
                    if (eos) begin
                        emit = 1'b1;
                        st   = ST_TRUNC;
                    end else begin
                        n_pending = n_seq_len;
                    end
                end
            end else if (eos && r_pending > 2'd1) begin
                emit = 1'b1;
                st   = ST_TRUNC;
            end else if (i_word.cls != BC_CONT) begin
                emit = 1'b1;
                st   = ST_BADCONT;
            end else begin
                // Continuation byte: shift in six bits; check on the last one.
                n_partial = new_part;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    emit = 1'b1;
                    st   = check_done(r_seq_len, new_part);
                    if (st == ST_OK) n_out.code_point = new_part;
                end
            end

            // State after a result: clear on end mark, drop after a fault.
            if (emit) begin
                n_pending = 2'd0;
                n_seq_len = 2'd0;
                n_partial = '0;
                if (!eos && st != ST_OK) n_dropping = 1'b1;
            end
            if (eos) begin
                n_pending  = 2'd0;
                n_seq_len  = 2'd0;
                n_partial  = '0;
                n_dropping = 1'b0;
            end
        end
        n_out.status = st;
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 2'd0;
            r_seq_len  <= 2'd0;
            r_partial  <= '0;
            r_dropping <= 1'b0;
        end else begin
            r_pending  <= n_pending;
            r_seq_len  <= n_seq_len;
            r_partial  <= n_partial;
            r_dropping <= n_dropping;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (pop && emit) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

`ifndef SYNTH
    // While dropping, no sequence is open.
    a_drop_no_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_pending == 2'd0 && r_seq_len == 2'd0))
        else $error("dropping with an open sequence");

    // Pending count never exceeds the open sequence length.
    a_pending_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= r_seq_len)
        else $error("pending count above sequence length");

    // A faulty result carries a zero code point.
    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.code_point == '0))
        else $error("error result with nonzero code point");

    // A fault on a byte that is not end-marked starts dropping.
    a_fault_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && emit && st != ST_OK && !eos) |=> r_dropping)
        else $error("fault did not start dropping");

    // An end-marked byte always leaves the decoder cleared.
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && eos) |=> (r_pending == 2'd0 && !r_dropping))
        else $error("end mark did not clear the decoder");
`endif

endmodule

`default_nettype wire

>>> src/utf8_to_utf32_decoder.sv
// UTF-8 byte stream to 21-bit code point decoder with validation: top level.
//
// Input channel (i_valid/o_ready, i_word): one byte of a UTF-8 string per word,
// with end_of_string set on the final byte. Output channel (o_valid/i_ready,
// o_word): at most one result per byte, a code point with a status and a
// flag that marks results caused by the end-marked byte.
// Throughput is one byte per cycle while the receiver keeps up. A result
// reaches the output register after its byte passes the front register and
// the queue; bytes that only open or extend a sequence give no result.
// The path is three parts: a classifying front register, a two-word queue,
// and a decoding back end whose output register holds one result.
// After the first fault in a string, bytes are dropped without results until
// the end-marked byte, which clears the decoder.
// When the receiver stalls, the output register holds its word, the back end
// stops taking bytes, the queue and front register fill, and then o_ready
// drops. Synchronous reset empties all stages and clears the decoder; no
// result is pending after reset.
`default_nettype none

module utf8_to_utf32_decoder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  utf8d_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  wire                  i_ready,
    output utf8d_pkg::t_out_word o_word
);
    import utf8d_pkg::*;

    logic      fr_valid;
    logic      fr_ready;
    t_cls_word fr_word;
    logic      q_valid;
    logic      q_ready;
    t_cls_word q_word;

    // Classifying front register.
    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_word  (fr_word)
    );

    // Queue between front and back.
    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_word  (fr_word),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_word  (q_word)
    );

    // Sequence decoder with output register.
    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_word  (q_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire
